FILE: rtl/simplex_centered_rank_core_assert.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef SIMPLEX_CENTERED_RANK_CORE_ASSERT_SVH
`define SIMPLEX_CENTERED_RANK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCR_ASSERT(lbl, prop, msg)
`define SCR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/scr_pkg.sv
`default_nettype none
package scr_pkg;

  localparam int DIMENSION_DEF  = 2;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int COORD_W   = 16;
  localparam int IDX_W     = 6;
  localparam int RANK_W    = 51;
  localparam int CFG_W     = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam int FRAC_W = 16;
  localparam int MAT_W  = 17;             // coordinate difference
  localparam int T_W    = 2 * MAT_W + 1;  // 2x2 minor
  localparam int PROD_W = MAT_W + T_W;
  localparam int D_W    = PROD_W + 2;     // full 3x3 determinant
  localparam int ACC_W  = 52;
  localparam int TOT_W  = 16;             // up to C(64,3) subsets
  localparam int DVD_W  = ACC_W + FRAC_W;
  localparam int DC_W   = 7;

  typedef struct packed {
    logic [1:0] a_r;
    logic [1:0] a_c;
    logic [1:0] b_r;
    logic [1:0] b_c;
    logic       b_t;   // second operand is the minor register
    logic       neg;
    logic       to_d;  // 1: determinant register, 0: minor register
    logic       load;
  } mac_op_t;

  typedef struct packed {
    logic       mem_we;
    logic       cap;
    logic [1:0] cap_i;
    logic [1:0] cap_j;
    logic       acc_clr;
    logic       tot_inc;
    logic       mat_diff;
    logic       mat_cof;
    logic [1:0] u;
    logic       mul_go;
    logic       add_go;
    mac_op_t    op;
    logic       sign_cap;
    logic       acc_upd;
    logic       div_load;
    logic       div_step;
    logic       div_store;
  } dp_cmd_t;

  typedef struct packed {
    logic d_zero;
  } dp_stat_t;

  function automatic mac_op_t mk_op(input logic [1:0] ar, input logic [1:0] ac,
                                    input logic [1:0] br, input logic [1:0] bc,
                                    input logic bt, input logic ng,
                                    input logic td, input logic ld);
    mac_op_t op;
    op.a_r = ar; op.a_c = ac; op.b_r = br; op.b_c = bc;
    op.b_t = bt; op.neg = ng; op.to_d = td; op.load = ld;
    return op;
  endfunction

  function automatic logic [3:0] mac_steps(input int dim);
    return (dim == 2) ? 4'd2 : 4'd9;
  endfunction

  // Determinant microsequence; 3x3 expands along row 0 through 2x2 minors.
  function automatic mac_op_t mac_step(input int dim, input logic [3:0] k);
    mac_op_t op;
    op = '0;
    if (dim == 2) begin
      case (k)
        4'd0:    op = mk_op(2'd0, 2'd0, 2'd1, 2'd1, 1'b0, 1'b0, 1'b1, 1'b1);
        4'd1:    op = mk_op(2'd0, 2'd1, 2'd1, 2'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        default: op = '0;
      endcase
    end else begin
      case (k)
        4'd0:    op = mk_op(2'd1, 2'd1, 2'd2, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1);
        4'd1:    op = mk_op(2'd1, 2'd2, 2'd2, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0);
        4'd2:    op = mk_op(2'd0, 2'd0, 2'd0, 2'd0, 1'b1, 1'b0, 1'b1, 1'b1);
        4'd3:    op = mk_op(2'd1, 2'd0, 2'd2, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1);
        4'd4:    op = mk_op(2'd1, 2'd2, 2'd2, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        4'd5:    op = mk_op(2'd0, 2'd1, 2'd0, 2'd0, 1'b1, 1'b1, 1'b1, 1'b0);
        4'd6:    op = mk_op(2'd1, 2'd0, 2'd2, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1);
        4'd7:    op = mk_op(2'd1, 2'd1, 2'd2, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        4'd8:    op = mk_op(2'd0, 2'd2, 2'd0, 2'd0, 1'b1, 1'b0, 1'b1, 1'b0);
        default: op = '0;
      endcase
    end
    return op;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/scr_datapath.sv
`default_nettype none
module scr_datapath #(
  parameter int DIMENSION  = scr_pkg::DIMENSION_DEF,
  parameter int MAX_POINTS = scr_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = scr_pkg::COORD_BITS_DEF,
  parameter int ADDR_W     = $clog2(MAX_POINTS * DIMENSION)
) (
  input  wire logic                                clk,
  input  wire scr_pkg::dp_cmd_t                    cmd,
  input  wire logic [ADDR_W-1:0]                   wr_addr,
  input  wire logic [ADDR_W-1:0]                   rd_addr,
  input  wire logic [scr_pkg::COORD_W-1:0]         in_coordinate,
  output scr_pkg::dp_stat_t                        stat,
  output logic signed [scr_pkg::RANK_W-1:0]        rank_x,
  output logic signed [scr_pkg::RANK_W-1:0]        rank_y,
  output logic signed [scr_pkg::RANK_W-1:0]        rank_z
);
  localparam int STORE_DEPTH = MAX_POINTS * DIMENSION;
  localparam int MAT_W  = scr_pkg::MAT_W;
  localparam int T_W    = scr_pkg::T_W;
  localparam int PROD_W = scr_pkg::PROD_W;
  localparam int D_W    = scr_pkg::D_W;
  localparam int ACC_W  = scr_pkg::ACC_W;
  localparam int TOT_W  = scr_pkg::TOT_W;
  localparam int DVD_W  = scr_pkg::DVD_W;
  localparam int RANK_W = scr_pkg::RANK_W;

  logic signed [COORD_BITS-1:0] mem [STORE_DEPTH];
  logic signed [COORD_BITS-1:0] rd_r;
  // rows 0..DIMENSION-1: subset points, row DIMENSION: point being ranked
  logic signed [COORD_BITS-1:0] prow_r [4][3];
  logic signed [MAT_W-1:0]      mat_r [3][3];
  logic signed [MAT_W-1:0]      mat_ld_c [3][3];
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [T_W-1:0]        t_r;
  logic signed [D_W-1:0]        d_r;
  logic                         sgn_r;
  logic signed [ACC_W-1:0]      acc_r [3];
  logic [TOT_W-1:0]             tot_r;
  logic [DVD_W-1:0]             dvd_r;
  logic [TOT_W-1:0]             rem_r;
  logic [RANK_W-1:0]            q_r;
  logic                         qneg_r;
  logic signed [RANK_W-1:0]     rank_r [3];

  logic signed [MAT_W-1:0]  a_c;
  logic signed [T_W-1:0]    b_c;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] val_c;
  logic signed [ACC_W-1:0]  cof_c;
  logic signed [ACC_W-1:0]  acc_sel_c;
  logic [ACC_W-1:0]         mag_c;
  logic [TOT_W:0]           rem_sh_c;
  logic                     ge_c;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[wr_addr] <= in_coordinate[COORD_BITS-1:0];
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      prow_r[cmd.cap_i][cmd.cap_j] <= rd_r;
    end
  end

  // Matrix for the sign test (rows minus point) or for cofactor u
  // (leading one, then the row with coordinate u dropped).
  always_comb begin
    logic [1:0] js;
    js = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_ld_c[i][j] = '0;
      end
    end
    if (cmd.mat_cof) begin
      for (int i = 0; i < DIMENSION; i++) begin
        mat_ld_c[i][0] = MAT_W'(1);
        for (int k = 0; k < DIMENSION - 1; k++) begin
          js = (2'(k) < cmd.u) ? 2'(k) : 2'(k + 1);
          mat_ld_c[i][k+1] = MAT_W'(prow_r[i][js]);
        end
      end
    end else begin
      for (int i = 0; i < DIMENSION; i++) begin
        for (int j = 0; j < DIMENSION; j++) begin
          mat_ld_c[i][j] = MAT_W'(prow_r[i][j]) - MAT_W'(prow_r[DIMENSION][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mat_diff || cmd.mat_cof) begin
      mat_r <= mat_ld_c;
    end
  end

  assign a_c    = mat_r[cmd.op.a_r][cmd.op.a_c];
  assign b_c    = cmd.op.b_t ? t_r : T_W'(mat_r[cmd.op.b_r][cmd.op.b_c]);
  assign prod_c = a_c * b_c;
  assign val_c  = cmd.op.neg ? -prod_r : prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= prod_c;
    end
    if (cmd.add_go) begin
      if (cmd.op.to_d) begin
        d_r <= cmd.op.load ? D_W'(val_c) : d_r + D_W'(val_c);
      end else begin
        t_r <= cmd.op.load ? T_W'(val_c) : t_r + T_W'(val_c);
      end
    end
    if (cmd.sign_cap) begin
      sgn_r <= d_r[D_W-1];
    end
  end

  // cofactor sign alternates: even components negated unless sgn_r is set
  assign cof_c = ACC_W'(d_r);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      for (int u = 0; u < 3; u++) begin
        acc_r[u] <= '0;
      end
      tot_r <= '0;
    end else begin
      if (cmd.tot_inc) begin
        tot_r <= tot_r + TOT_W'(1);
      end
      if (cmd.acc_upd) begin
        acc_r[cmd.u] <= acc_r[cmd.u] + ((sgn_r ^ ~cmd.u[0]) ? -cof_c : cof_c);
      end
    end
  end

  // Restoring divider: |sum| * 2^16 / subset count, one quotient bit a cycle
  assign acc_sel_c = acc_r[cmd.u];
  assign mag_c     = acc_sel_c[ACC_W-1] ? ACC_W'(-acc_sel_c) : ACC_W'(acc_sel_c);
  assign rem_sh_c  = {rem_r, dvd_r[DVD_W-1]};
  assign ge_c      = rem_sh_c >= {1'b0, tot_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r  <= {mag_c, {scr_pkg::FRAC_W{1'b0}}};
      qneg_r <= acc_sel_c[ACC_W-1];
      rem_r  <= '0;
      q_r    <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge_c ? TOT_W'(rem_sh_c - {1'b0, tot_r}) : TOT_W'(rem_sh_c);
      q_r   <= {q_r[RANK_W-2:0], ge_c};
    end
    if (cmd.div_store) begin
      if (tot_r == '0) begin
        rank_r[cmd.u] <= '0;
      end else begin
        rank_r[cmd.u] <= qneg_r ? RANK_W'(-q_r) : RANK_W'(q_r);
      end
    end
  end

  assign stat.d_zero = (d_r == '0);
  assign rank_x = rank_r[0];
  assign rank_y = rank_r[1];
  assign rank_z = (DIMENSION > 2) ? rank_r[2] : '0;

endmodule
`default_nettype wire

FILE: rtl/scr_ctrl.sv
`default_nettype none
`include "simplex_centered_rank_core_assert.svh"
module scr_ctrl #(
  parameter int DIMENSION  = scr_pkg::DIMENSION_DEF,
  parameter int MAX_POINTS = scr_pkg::MAX_POINTS_DEF,
  parameter int ADDR_W     = $clog2(MAX_POINTS * DIMENSION)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cfg_we,
  input  wire logic [scr_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [scr_pkg::IDX_W-1:0]          out_point_index,
  output logic                               out_last_point,
  output scr_pkg::dp_cmd_t                   cmd,
  output logic [ADDR_W-1:0]                  wr_addr,
  output logic [ADDR_W-1:0]                  rd_addr,
  input  wire scr_pkg::dp_stat_t             stat
);
  localparam int STORE_DEPTH = MAX_POINTS * DIMENSION;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CW1   = CNT_W + 1;
  localparam int NP_W  = $clog2(MAX_POINTS + 1);
  localparam int PT_W  = $clog2(MAX_POINTS);
  localparam int W2    = NP_W + 1;
  localparam int CFG_W = scr_pkg::CFG_W;
  localparam int DC_W  = scr_pkg::DC_W;
  localparam logic [3:0] NSTEP = scr_pkg::mac_steps(DIMENSION);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_PINIT    = 4'd1;
  localparam logic [3:0] S_FETCH    = 4'd2;
  localparam logic [3:0] S_FWAIT    = 4'd3;
  localparam logic [3:0] S_SIGN_SET = 4'd4;
  localparam logic [3:0] S_MAC      = 4'd5;
  localparam logic [3:0] S_SIGN_CHK = 4'd6;
  localparam logic [3:0] S_COF_SET  = 4'd7;
  localparam logic [3:0] S_COF_ACC  = 4'd8;
  localparam logic [3:0] S_ADV      = 4'd9;
  localparam logic [3:0] S_DIV_SET  = 4'd10;
  localparam logic [3:0] S_DIV      = 4'd11;
  localparam logic [3:0] S_DIV_ST   = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  logic [3:0]       state_r, state_nxt;
  logic [CFG_W-1:0] pcount_r;
  logic [CNT_W-1:0] load_cnt_r;
  logic [PT_W-1:0]  cur_r;
  logic [PT_W-1:0]  rows_r [3];
  logic [PT_W-1:0]  rows_nxt [3];
  logic [1:0]       fi_r, fj_r;
  logic             cap_r;
  logic [1:0]       cap_i_r, cap_j_r;
  logic [3:0]       k_r;
  logic             ph_r;
  logic             cof_r;
  logic [1:0]       u_r;
  logic [DC_W-1:0]  dc_r;

  logic [NP_W-1:0]  n_c;
  logic [CW1-1:0]   need_c;
  logic             trigger_c;
  logic             in_acc_c;
  logic             out_acc_c;
  logic             last_c;
  logic [PT_W-1:0]  row_c;
  logic             adv_ok_c;
  logic [1:0]       sel_c;
  logic             mac_end_c;

  // saturate the point count into 1..MAX_POINTS
  always_comb begin
    if (pcount_r > CFG_W'(MAX_POINTS)) begin
      n_c = NP_W'(MAX_POINTS);
    end else if (pcount_r == '0) begin
      n_c = NP_W'(1);
    end else begin
      n_c = NP_W'(pcount_r);
    end
  end

  assign need_c    = CW1'(n_c) * CW1'(DIMENSION);
  assign trigger_c = (CW1'(load_cnt_r) + CW1'(1)) >= need_c;
  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign in_acc_c  = in_valid && in_ready;
  assign out_acc_c = out_valid && out_ready;
  assign last_c    = (W2'(cur_r) + W2'(1)) == W2'(n_c);
  assign out_point_index = scr_pkg::IDX_W'(cur_r);
  assign out_last_point  = last_c;
  assign wr_addr   = load_cnt_r[ADDR_W-1:0];
  assign mac_end_c = ph_r && (k_r == NSTEP - 4'd1);

  always_comb begin
    row_c = cur_r;
    if (fi_r != 2'(DIMENSION)) begin
      row_c = rows_r[fi_r];
    end
  end
  assign rd_addr = ADDR_W'(ADDR_W'(row_c) * ADDR_W'(DIMENSION) + ADDR_W'(fj_r));

  // next subset in lexicographic order: bump the highest row that has room
  always_comb begin
    adv_ok_c = 1'b0;
    sel_c    = '0;
    for (int i = 0; i < DIMENSION; i++) begin
      if (W2'(rows_r[i]) + W2'(DIMENSION - i) < W2'(n_c)) begin
        adv_ok_c = 1'b1;
        sel_c    = 2'(i);
      end
    end
    for (int j = 0; j < 3; j++) begin
      rows_nxt[j] = rows_r[j];
      if (2'(j) >= sel_c) begin
        rows_nxt[j] = PT_W'(W2'(rows_r[sel_c]) + W2'(1) + W2'(2'(j) - sel_c));
      end
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.mem_we   = in_acc_c;
    cmd.cap      = cap_r;
    cmd.cap_i    = cap_i_r;
    cmd.cap_j    = cap_j_r;
    cmd.u        = u_r;
    cmd.op       = scr_pkg::mac_step(DIMENSION, k_r);
    unique case (state_r)
      S_PINIT:    cmd.acc_clr = 1'b1;
      S_SIGN_SET: begin
        cmd.mat_diff = 1'b1;
        cmd.tot_inc  = 1'b1;
      end
      S_MAC: begin
        cmd.mul_go = !ph_r;
        cmd.add_go = ph_r;
      end
      S_SIGN_CHK: cmd.sign_cap  = !stat.d_zero;
      S_COF_SET:  cmd.mat_cof   = 1'b1;
      S_COF_ACC:  cmd.acc_upd   = 1'b1;
      S_DIV_SET:  cmd.div_load  = 1'b1;
      S_DIV:      cmd.div_step  = 1'b1;
      S_DIV_ST:   cmd.div_store = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:     if (in_acc_c && trigger_c) state_nxt = S_PINIT;
      S_PINIT:    state_nxt = (W2'(n_c) < W2'(DIMENSION)) ? S_DIV_SET : S_FETCH;
      S_FETCH: begin
        if (fi_r == 2'(DIMENSION) && fj_r == 2'(DIMENSION - 1)) state_nxt = S_FWAIT;
      end
      S_FWAIT:    state_nxt = S_SIGN_SET;
      S_SIGN_SET: state_nxt = S_MAC;
      S_MAC:      if (mac_end_c) state_nxt = cof_r ? S_COF_ACC : S_SIGN_CHK;
      S_SIGN_CHK: state_nxt = stat.d_zero ? S_ADV : S_COF_SET;
      S_COF_SET:  state_nxt = S_MAC;
      S_COF_ACC:  state_nxt = (u_r == 2'(DIMENSION - 1)) ? S_ADV : S_COF_SET;
      S_ADV:      state_nxt = adv_ok_c ? S_FETCH : S_DIV_SET;
      S_DIV_SET:  state_nxt = S_DIV;
      S_DIV:      if (dc_r == DC_W'(scr_pkg::DVD_W - 1)) state_nxt = S_DIV_ST;
      S_DIV_ST:   state_nxt = (u_r == 2'(DIMENSION - 1)) ? S_OUT : S_DIV_SET;
      S_OUT:      if (out_acc_c) state_nxt = last_c ? S_LOAD : S_PINIT;
      default:    state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      pcount_r   <= scr_pkg::CFG_RESET;
      load_cnt_r <= '0;
      cur_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        rows_r[i] <= '0;
      end
      fi_r    <= '0;
      fj_r    <= '0;
      cap_r   <= 1'b0;
      cap_i_r <= '0;
      cap_j_r <= '0;
      k_r     <= '0;
      ph_r    <= 1'b0;
      cof_r   <= 1'b0;
      u_r     <= '0;
      dc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        pcount_r <= cfg_wdata;
      end
      cap_r   <= (state_r == S_FETCH);
      cap_i_r <= fi_r;
      cap_j_r <= fj_r;
      case (state_r)
        S_LOAD: begin
          if (in_acc_c) begin
            load_cnt_r <= trigger_c ? '0 : load_cnt_r + CNT_W'(1);
            cur_r      <= '0;
          end
        end
        S_PINIT: begin
          for (int i = 0; i < 3; i++) begin
            rows_r[i] <= PT_W'(i);
          end
          fi_r <= '0;
          fj_r <= '0;
          u_r  <= '0;
        end
        S_FETCH: begin
          if (fj_r == 2'(DIMENSION - 1)) begin
            fj_r <= '0;
            fi_r <= fi_r + 2'd1;
          end else begin
            fj_r <= fj_r + 2'd1;
          end
        end
        S_SIGN_SET: begin
          k_r   <= '0;
          ph_r  <= 1'b0;
          cof_r <= 1'b0;
        end
        S_MAC: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            k_r <= mac_end_c ? '0 : k_r + 4'd1;
          end
        end
        S_SIGN_CHK: u_r <= '0;
        S_COF_SET: begin
          k_r   <= '0;
          ph_r  <= 1'b0;
          cof_r <= 1'b1;
        end
        S_COF_ACC: u_r <= u_r + 2'd1;
        S_ADV: begin
          fi_r <= '0;
          fj_r <= '0;
          u_r  <= '0;
          if (adv_ok_c) begin
            rows_r <= rows_nxt;
          end
        end
        S_DIV_SET: dc_r <= '0;
        S_DIV:     dc_r <= dc_r + DC_W'(1);
        S_DIV_ST:  u_r  <= u_r + 2'd1;
        S_OUT: begin
          if (out_acc_c && !last_c) begin
            cur_r <= cur_r + PT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `SCR_ASSERT(a_hs_exclusive, !(in_ready && out_valid), "input open while a result waits")
  `SCR_ASSERT_NEXT(a_last_reload, out_acc_c && last_c, in_ready && (load_cnt_r == '0), "no reload after last point")
  `SCR_ASSERT(a_rows_order, (state_r != S_FETCH) || (rows_r[0] < rows_r[1]), "subset rows out of order")
  `SCR_ASSERT(a_div_len, (state_r != S_DIV) || (dc_r < DC_W'(scr_pkg::DVD_W)), "divider overran")

endmodule
`default_nettype wire

FILE: rtl/simplex_centered_rank_core.sv
`default_nettype none
// Oja centered rank core. Coordinates are taken one per cycle, row-major,
// until point_count points are loaded; the input then closes while every
// point is ranked and one result per point is delivered, in index order, the
// last flagged by out_last_point. A single shared multiplier under a
// microsequencer sets the ranking time: for each subset, coordinate fetches
// from the point memory and one multiply then one accumulate per product,
// with less work when the subset's determinant is zero; then DIMENSION
// bit-serial divisions per point, and a handshake per result.
module simplex_centered_rank_core #(
  parameter int DIMENSION  = scr_pkg::DIMENSION_DEF,
  parameter int MAX_POINTS = scr_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = scr_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [scr_pkg::COORD_W-1:0]        in_coordinate,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [scr_pkg::IDX_W-1:0]               out_point_index,
  output logic signed [scr_pkg::RANK_W-1:0]       out_rank_x,
  output logic signed [scr_pkg::RANK_W-1:0]       out_rank_y,
  output logic signed [scr_pkg::RANK_W-1:0]       out_rank_z,
  output logic                                    out_last_point,
  input  wire logic                               cfg_we,
  input  wire logic [scr_pkg::CFG_W-1:0]          cfg_wdata
);
  localparam int ADDR_W = $clog2(MAX_POINTS * DIMENSION);

  scr_pkg::dp_cmd_t  cmd;
  scr_pkg::dp_stat_t stat;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  scr_ctrl #(
    .DIMENSION  (DIMENSION),
    .MAX_POINTS (MAX_POINTS),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_index (out_point_index),
    .out_last_point  (out_last_point),
    .cmd             (cmd),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .stat            (stat)
  );

  scr_datapath #(
    .DIMENSION  (DIMENSION),
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .ADDR_W     (ADDR_W)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .in_coordinate (in_coordinate),
    .stat          (stat),
    .rank_x        (out_rank_x),
    .rank_y        (out_rank_y),
    .rank_z        (out_rank_z)
  );

endmodule
`default_nettype wire
